// ----- hw/rtl/amex_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amex_pkg
// shared types and constants of the decimal accumulator machine executor
// ----------------------------------------------------------------------------
package amex_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned ADDR_W  = 7;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned OP_W    = 6;

   // opcodes
   localparam logic [OP_W-1:0] OP_READ   = 6'd10;
   localparam logic [OP_W-1:0] OP_WRITE  = 6'd11;
   localparam logic [OP_W-1:0] OP_LOAD   = 6'd20;
   localparam logic [OP_W-1:0] OP_STORE  = 6'd21;
   localparam logic [OP_W-1:0] OP_ADD    = 6'd30;
   localparam logic [OP_W-1:0] OP_SUB    = 6'd31;
   localparam logic [OP_W-1:0] OP_DIV    = 6'd32;
   localparam logic [OP_W-1:0] OP_MUL    = 6'd33;
   localparam logic [OP_W-1:0] OP_BR     = 6'd40;
   localparam logic [OP_W-1:0] OP_BRNEG  = 6'd41;
   localparam logic [OP_W-1:0] OP_BRZERO = 6'd42;
   localparam logic [OP_W-1:0] OP_HALT   = 6'd43;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

   // decimal split of an instruction word by reciprocal multiply
   localparam int unsigned DEC_W     = 13;
   localparam int unsigned PROD_W    = 2 * DEC_W;
   localparam int unsigned DEC_SHIFT = 19;
   localparam logic [DEC_W-1:0] DEC_MUL    = 13'd5243;
   localparam logic [DEC_W-1:0] DEC_RADIX  = 13'd100;
   localparam logic [DATA_W-1:0] WORD_MIN   = 32'd1000;
   localparam logic [DATA_W-1:0] WORD_LIMIT = 32'd4400;

   typedef struct packed {
      logic                     func;
      logic [ADDR_W-1:0]        address;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     out_valid;
      logic                     halted;
      logic [ERR_W-1:0]         error_code;
      logic signed [DATA_W-1:0] acc_value;
      logic [ADDR_W-1:0]        pc_value;
      logic [COUNT_W-1:0]       executed_count;
   } rsp_type;

endpackage

// ----- hw/rtl/amex_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amex_div
// iterative signed divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module amex_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [amex_pkg::DATA_W-1:0] dividend,
   input  logic signed [amex_pkg::DATA_W-1:0] divisor,
   output logic                               done,
   output logic signed [amex_pkg::DATA_W-1:0] quotient
);

   localparam int unsigned W     = amex_pkg::DATA_W;
   localparam int unsigned CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     quo_ff;
   logic [W-1:0]     dvs_ff;
   logic             neg_ff;
   logic [W-1:0]     quotient_ff;

   logic [W:0]   rem_shift;
   logic [W:0]   diff;
   logic         fits;
   logic [W-1:0] rem_in;
   logic [W-1:0] quo_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[W-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      fits      = !diff[W];
      rem_in    = fits ? diff[W-1:0] : rem_shift[W-1:0];
      quo_in    = {quo_ff[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend[W-1] ? (W'(0) - W'(dividend)) : W'(dividend);
         dvs_ff <= divisor[W-1] ? (W'(0) - W'(divisor)) : W'(divisor);
         neg_ff <= dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (cnt_ff == CNT_LAST) begin
            quotient_ff <= neg_ff ? (W'(0) - quo_in) : quo_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;

endmodule

// ----- hw/rtl/accumulator_machine_executor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_executor_top
// decimal accumulator machine with word memory, one instruction per transaction
// ----------------------------------------------------------------------------
// A func 0 transaction writes one memory word and goes straight to the result
// step; a func 1 transaction, unless the machine has halted, fetches, splits
// and executes one instruction through the fetch, decode, split, operand and
// execute states, and a divide then waits in the divide state while its 32
// quotient bits come from the divider one per cycle. The single memory port
// (one read and one write a cycle, read data registered) sets the fetch and
// operand read steps. One transaction is in flight at a time; the result
// register lets the next transaction start while a result waits. Memory words
// read as zero until written since reset.
// ----------------------------------------------------------------------------
module accumulator_machine_executor_top #(
   parameter int unsigned MEM_WORDS = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  amex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output amex_pkg::rsp_type rsp_data
);

   localparam int unsigned DW    = amex_pkg::DATA_W;
   localparam int unsigned AW    = amex_pkg::ADDR_W;
   localparam int unsigned CW    = amex_pkg::COUNT_W;
   localparam int unsigned OW    = amex_pkg::OP_W;
   localparam int unsigned IDX_W = $clog2(MEM_WORDS);
   localparam logic [AW-1:0] ADDR_LIMIT = AW'(MEM_WORDS);
   localparam logic [AW:0]   PC_LIMIT   = (AW + 1)'(MEM_WORDS);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_DECODE, S_SPLIT, S_OPERAND, S_EXEC, S_DIV, S_RESP
   } state_type;

   state_type                       state_ff;
   amex_pkg::req_type               req_ff;
   logic                            halt_ff;
   logic signed [DW-1:0]            acc_ff;
   logic [AW-1:0]                   pc_ff;
   logic [CW-1:0]                   count_ff;
   logic [DW-1:0]                   shown_ff;
   logic                            shown_valid_ff;
   logic [amex_pkg::ERR_W-1:0]      err_ff;
   logic [amex_pkg::DEC_W-1:0]      dec_word_ff;
   logic [amex_pkg::PROD_W-1:0]     prod_ff;
   logic                            range_ok_ff;
   logic [OW-1:0]                   op_ff;
   logic [AW-1:0]                   opnd_ff;
   logic                            rsp_valid_ff;
   amex_pkg::rsp_type               rsp_data_ff;

   logic [DW-1:0]                   mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]            valid_ff;
   logic [DW-1:0]                   rd_data_ff;
   logic                            rd_ok_ff;

   logic [AW-1:0]                   rd_addr;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [DW-1:0]                   wr_data;
   logic                            rd_in_range;
   logic                            wr_in_range;
   logic [IDX_W-1:0]                rd_idx;
   logic [IDX_W-1:0]                wr_idx;

   logic [DW-1:0]                   opnd_word;
   logic                            word_ok_in;
   logic [amex_pkg::PROD_W-1:0]     prod_in;
   logic [OW-1:0]                   op_in;
   logic [amex_pkg::DEC_W-1:0]      rem_full;
   logic                            taken;
   logic [AW:0]                     next_full;
   logic [AW-1:0]                   next_pc;
   logic [DW-1:0]                   mul_lo;
   logic                            div_start;
   logic                            div_done;
   logic signed [DW-1:0]            div_quot;
   logic                            accept;
   logic                            rsp_load;
   amex_pkg::rsp_type               rsp_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // memory port control
   always_comb begin
      rd_addr = pc_ff;
      wr_en   = 1'b0;
      wr_addr = req_data.address;
      wr_data = req_data.value;
      unique case (state_ff)
         S_IDLE: begin
            wr_en = req_valid && !req_data.func;
         end
         S_OPERAND: begin
            rd_addr = opnd_ff;
         end
         S_EXEC: begin
            wr_addr = opnd_ff;
            wr_en   = range_ok_ff
                      && ((op_ff == amex_pkg::OP_READ) || (op_ff == amex_pkg::OP_STORE));
            wr_data = (op_ff == amex_pkg::OP_READ) ? req_ff.value : acc_ff;
         end
         default: begin
         end
      endcase
   end

   assign rd_in_range = (rd_addr < ADDR_LIMIT);
   assign wr_in_range = (wr_addr < ADDR_LIMIT);
   assign rd_idx      = rd_addr[IDX_W-1:0];
   assign wr_idx      = wr_addr[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en && wr_in_range) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         rd_ok_ff <= rd_in_range && valid_ff[rd_idx];
      end
   end

   assign opnd_word = rd_ok_ff ? rd_data_ff : '0;

   // decimal split: opcode by reciprocal multiply, operand by remainder
   always_comb begin
      word_ok_in = !opnd_word[DW-1] && (opnd_word >= amex_pkg::WORD_MIN)
                   && (opnd_word < amex_pkg::WORD_LIMIT);
      prod_in    = opnd_word[amex_pkg::DEC_W-1:0] * amex_pkg::DEC_MUL;
      op_in      = prod_ff[amex_pkg::DEC_SHIFT +: OW];
      rem_full   = dec_word_ff - (amex_pkg::DEC_W'(op_in) * amex_pkg::DEC_RADIX);
   end

   // sequencing
   always_comb begin
      taken = 1'b0;
      if (range_ok_ff) begin
         case (op_ff)
            amex_pkg::OP_BR:     taken = 1'b1;
            amex_pkg::OP_BRNEG:  taken = acc_ff[DW-1];
            amex_pkg::OP_BRZERO: taken = (acc_ff == '0);
            default:             taken = 1'b0;
         endcase
      end
      next_full = taken ? {1'b0, opnd_ff} : ({1'b0, pc_ff} + (AW + 1)'(1));
      next_pc   = (next_full < PC_LIMIT) ? next_full[AW-1:0] : '0;
   end

   assign mul_lo    = acc_ff * opnd_word;
   assign div_start = (state_ff == S_EXEC) && range_ok_ff
                      && (op_ff == amex_pkg::OP_DIV) && (opnd_word != '0);

   amex_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (opnd_word),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      rsp_in.out_value      = shown_ff;
      rsp_in.out_valid      = shown_valid_ff;
      rsp_in.halted         = halt_ff;
      rsp_in.error_code     = err_ff;
      rsp_in.acc_value      = acc_ff;
      rsp_in.pc_value       = pc_ff;
      rsp_in.executed_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halt_ff      <= 1'b0;
         acc_ff       <= '0;
         pc_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff         <= req_data;
                  shown_ff       <= '0;
                  shown_valid_ff <= 1'b0;
                  err_ff         <= amex_pkg::ERR_NONE;
                  state_ff       <= (req_data.func && !halt_ff) ? S_FETCH : S_RESP;
               end
            end
            S_FETCH: begin
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               dec_word_ff <= opnd_word[amex_pkg::DEC_W-1:0];
               prod_ff     <= prod_in;
               range_ok_ff <= word_ok_in;
               state_ff    <= S_SPLIT;
            end
            S_SPLIT: begin
               op_ff    <= op_in;
               opnd_ff  <= rem_full[AW-1:0];
               state_ff <= S_OPERAND;
            end
            S_OPERAND: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               count_ff <= count_ff + CW'(1);
               pc_ff    <= next_pc;
               state_ff <= div_start ? S_DIV : S_RESP;
               if (!range_ok_ff) begin
                  err_ff <= amex_pkg::ERR_UNKNOWN;
               end else begin
                  case (op_ff) inside
                     amex_pkg::OP_READ, amex_pkg::OP_STORE, amex_pkg::OP_BR,
                     amex_pkg::OP_BRNEG, amex_pkg::OP_BRZERO: begin
                     end
                     amex_pkg::OP_WRITE: begin
                        shown_ff       <= opnd_word;
                        shown_valid_ff <= 1'b1;
                     end
                     amex_pkg::OP_LOAD: acc_ff <= opnd_word;
                     amex_pkg::OP_ADD:  acc_ff <= acc_ff + opnd_word;
                     amex_pkg::OP_SUB:  acc_ff <= acc_ff - opnd_word;
                     amex_pkg::OP_MUL:  acc_ff <= mul_lo;
                     amex_pkg::OP_DIV: begin
                        if (opnd_word == '0) begin
                           err_ff  <= amex_pkg::ERR_DIVZERO;
                           halt_ff <= 1'b1;
                        end
                     end
                     amex_pkg::OP_HALT: halt_ff <= 1'b1;
                     default: err_ff <= amex_pkg::ERR_UNKNOWN;
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  acc_ff   <= div_quot;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_load) begin
                  rsp_data_ff <= rsp_in;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/amex_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amex_checker
// port-level checks of the accumulator machine executor, bound to the top level
// ----------------------------------------------------------------------------
module amex_checker #(
   parameter int unsigned MEM_WORDS = 100
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input amex_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input amex_pkg::rsp_type rsp_data
);

   localparam logic [amex_pkg::ADDR_W-1:0] ADDR_LIMIT = amex_pkg::ADDR_W'(MEM_WORDS);

   logic req_func_unused;
   assign req_func_unused = req_data.func;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transaction was taken");

   a_pc_in_memory: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pc_value < ADDR_LIMIT)
      else $error("program counter outside memory");

   a_divzero_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code == amex_pkg::ERR_DIVZERO) |-> rsp_data.halted)
      else $error("divide by zero without halt");

   a_shown_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> (rsp_data.out_value == '0))
      else $error("shown word nonzero without write opcode");

endmodule

bind accumulator_machine_executor_top amex_checker #(
   .MEM_WORDS (MEM_WORDS)
) u_amex_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- test/accumulator_machine_executor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_executor_top_tb
// Self-checking testbench for the decimal accumulator machine. A scoreboard
// class keeps its own copy of the word memory and machine registers. It
// predicts one result for each accepted request and compares every field of
// each accepted response, in order. Stimulus starts with a hand-built program
// that covers wraparound arithmetic, the most negative value divided by minus
// one, taken and untaken branches, pc wrap and an unknown opcode. It goes on
// with random programs written into memory and then run, mixed with noise
// words and writes outside memory. The run ends by stopping the machine,
// through a halt or a divide by zero, and by poking the stopped machine. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module accumulator_machine_executor_top_tb;

   localparam int MEM_WORDS     = 100;
   localparam int RANDOM_ITEMS  = 750;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DW            = amex_pkg::DATA_W;
   localparam int AW            = amex_pkg::ADDR_W;
   localparam int CW            = amex_pkg::COUNT_W;
   localparam int OW            = amex_pkg::OP_W;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   amex_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   amex_pkg::rsp_type rsp_data;

   class machine_scoreboard;
      logic [DW-1:0]     words [MEM_WORDS];
      logic [DW-1:0]     acc;
      logic [AW-1:0]     pc;
      logic [CW-1:0]     count;
      logic              halted;
      amex_pkg::rsp_type expected_q [$];
      int                mismatches;

      function new();
         foreach (words[i]) words[i] = '0;
         acc        = '0;
         pc         = '0;
         count      = '0;
         halted     = 1'b0;
         mismatches = 0;
      endfunction

      function logic [DW-1:0] signed_quotient(logic [DW-1:0] n, logic [DW-1:0] d);
         logic [DW-1:0] un, ud, q;
         un = n[DW-1] ? -n : n;
         ud = d[DW-1] ? -d : d;
         q  = un / ud;
         return (n[DW-1] != d[DW-1]) ? -q : q;
      endfunction

      function amex_pkg::rsp_type execute_item(amex_pkg::req_type item);
         amex_pkg::rsp_type r;
         logic [DW-1:0]     word, operand;
         int unsigned       opcode, target, next;
         r = '0;
         if (!item.func) begin
            if (item.address < MEM_WORDS) words[item.address] = item.value;
         end else if (!halted) begin
            word   = words[pc];
            next   = pc + 1;
            opcode = 32'hFFFF;
            target = 0;
            if (!word[DW-1]) begin
               opcode = word / 100;
               target = word % 100;
            end
            operand = (target < MEM_WORDS) ? words[target] : '0;
            case (opcode)
               amex_pkg::OP_READ: if (target < MEM_WORDS) words[target] = item.value;
               amex_pkg::OP_WRITE: begin
                  r.out_value = operand;
                  r.out_valid = 1'b1;
               end
               amex_pkg::OP_LOAD:  acc = operand;
               amex_pkg::OP_STORE: if (target < MEM_WORDS) words[target] = acc;
               amex_pkg::OP_ADD:   acc = acc + operand;
               amex_pkg::OP_SUB:   acc = acc - operand;
               amex_pkg::OP_DIV: begin
                  if (operand == '0) begin
                     r.error_code = amex_pkg::ERR_DIVZERO;
                     halted       = 1'b1;
                  end else begin
                     acc = signed_quotient(acc, operand);
                  end
               end
               amex_pkg::OP_MUL:    acc = acc * operand;
               amex_pkg::OP_BR:     next = target;
               amex_pkg::OP_BRNEG:  if (acc[DW-1]) next = target;
               amex_pkg::OP_BRZERO: if (acc == '0) next = target;
               amex_pkg::OP_HALT:   halted = 1'b1;
               default:             r.error_code = amex_pkg::ERR_UNKNOWN;
            endcase
            pc    = AW'((next < MEM_WORDS) ? next : 0);
            count = count + 1'b1;
         end
         r.halted         = halted;
         r.acc_value      = acc;
         r.pc_value       = pc;
         r.executed_count = count;
         return r;
      endfunction

      // true when the instruction at pc would halt the machine for good
      function bit next_stops_machine();
         logic [DW-1:0] word;
         int unsigned   opcode, target;
         word = words[pc];
         if (halted || word[DW-1]) return 1'b0;
         opcode = word / 100;
         target = word % 100;
         return (opcode == amex_pkg::OP_HALT)
                || (opcode == amex_pkg::OP_DIV && words[target] == '0);
      endfunction

      function void note_request(amex_pkg::req_type item);
         expected_q.push_back(execute_item(item));
      endfunction

      function void check_response(amex_pkg::rsp_type got);
         amex_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction at %0t: acc=%h pc=%0d count=%0d",
                        $time, got.acc_value, got.pc_value, got.executed_count);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_value !== want.out_value || got.out_valid !== want.out_valid ||
             got.halted !== want.halted || got.error_code !== want.error_code ||
             got.acc_value !== want.acc_value || got.pc_value !== want.pc_value ||
             got.executed_count !== want.executed_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t: expected out=%h/%b halt=%b err=%0d ",
                        $time, want.out_value, want.out_valid, want.halted,
                        want.error_code,
                        "acc=%h pc=%0d count=%0d, actual out=%h/%b halt=%b err=%0d ",
                        want.acc_value, want.pc_value, want.executed_count,
                        got.out_value, got.out_valid, got.halted, got.error_code,
                        "acc=%h pc=%0d count=%0d",
                        got.acc_value, got.pc_value, got.executed_count);
         end
      endfunction
   endclass

   machine_scoreboard sb;
   int                items_sent  = 0;
   int                send_quiet  = 0;
   int                take_quiet  = 0;
   int unsigned       cycle_count = 0;

   accumulator_machine_executor_top #(
      .MEM_WORDS(MEM_WORDS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // random gap, with occasional stretches of none
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         quiet = $urandom_range(15, 50);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [AW-1:0] rand_addr(int unsigned lo, int unsigned hi);
      return AW'($urandom_range(lo, hi));
   endfunction

   function automatic logic [DW-1:0] encode(logic [OW-1:0] op, int unsigned operand);
      return int'(op) * 100 + operand;
   endfunction

   function automatic logic [OW-1:0] pick_op();
      case ($urandom_range(0, 10))
         0:       return amex_pkg::OP_READ;
         1:       return amex_pkg::OP_WRITE;
         2:       return amex_pkg::OP_LOAD;
         3:       return amex_pkg::OP_STORE;
         4:       return amex_pkg::OP_ADD;
         5:       return amex_pkg::OP_SUB;
         6:       return amex_pkg::OP_DIV;
         7:       return amex_pkg::OP_MUL;
         8:       return amex_pkg::OP_BR;
         9:       return amex_pkg::OP_BRNEG;
         default: return amex_pkg::OP_BRZERO;
      endcase
   endfunction

   function automatic logic [DW-1:0] random_data();
      case ($urandom_range(0, 6))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DW-1:0] random_instr(int unsigned base, int unsigned len);
      logic [OW-1:0] op;
      int unsigned   target;
      // noise: any word, words below the first opcode, words past the last
      case ($urandom_range(0, 19))
         0:       return $urandom;
         1:       return $urandom_range(0, 999);
         2:       return $urandom_range(4400, 99999);
         default: ;
      endcase
      op     = pick_op();
      target = $urandom_range(0, MEM_WORDS - 1);
      if ((op == amex_pkg::OP_BR || op == amex_pkg::OP_BRNEG || op == amex_pkg::OP_BRZERO)
          && $urandom_range(0, 3) != 0)
         target = (base + $urandom_range(0, len - 1)) % MEM_WORDS;
      return encode(op, target);
   endfunction

   task automatic send_item(input logic func, input logic [AW-1:0] address,
                            input logic [DW-1:0] value);
      amex_pkg::req_type item;
      int                gap;
      item.func    = func;
      item.address = address;
      item.value   = value;
      gap          = draw_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic write_word(input logic [AW-1:0] address, input logic [DW-1:0] value);
      send_item(1'b0, address, value);
   endtask

   task automatic execute(input logic [DW-1:0] value);
      send_item(1'b1, rand_addr(0, 127), value);
   endtask

   // the machine must keep running until the closing phase
   task automatic step_program(input logic [DW-1:0] value);
      if (sb.next_stops_machine())
         write_word(sb.pc, encode(amex_pkg::OP_LOAD, $urandom_range(0, MEM_WORDS - 1)));
      execute(value);
   endtask

   task automatic run_program();
      int unsigned base, len, i;
      base = 32'(sb.pc);
      len  = $urandom_range(3, 12);
      repeat ($urandom_range(0, 3))
         write_word(rand_addr(0, MEM_WORDS - 1), random_data());
      for (i = 0; i < len; i++)
         write_word(AW'((base + i) % MEM_WORDS), random_instr(base, len));
      if ($urandom_range(0, 7) == 0)
         write_word(rand_addr(MEM_WORDS, 127), random_data());
      repeat ($urandom_range(len, 2 * len)) step_program(random_data());
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(take_quiet);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

   initial begin
      int          directed_items;
      int unsigned divisor_addr;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // overflow, most negative over minus one, branches, pc wrap, unknown opcode
      write_word(90, 32'h7FFF_FFFF);
      write_word(93, 32'hFFFF_FFFF);
      write_word(0, encode(amex_pkg::OP_LOAD, 90));
      write_word(1, encode(amex_pkg::OP_ADD, 90));
      write_word(2, encode(amex_pkg::OP_MUL, 93));
      write_word(3, encode(amex_pkg::OP_SUB, 93));
      write_word(4, encode(amex_pkg::OP_STORE, 96));
      write_word(5, encode(amex_pkg::OP_READ, 95));
      write_word(6, encode(amex_pkg::OP_LOAD, 95));
      write_word(7, encode(amex_pkg::OP_DIV, 93));
      write_word(8, encode(amex_pkg::OP_BRNEG, 10));
      write_word(10, encode(amex_pkg::OP_BRZERO, 40));
      write_word(11, encode(amex_pkg::OP_WRITE, 96));
      write_word(12, encode(amex_pkg::OP_BR, 99));
      write_word(127, 32'h5A5A_A5A5);
      repeat (5) execute($urandom);
      execute(32'h8000_0000);
      repeat (7) execute($urandom);

      directed_items = items_sent;
      while (items_sent - directed_items < RANDOM_ITEMS) run_program();

      // stop the machine one way or the other, then poke it
      if ($urandom_range(0, 1)) begin
         write_word(sb.pc, encode(amex_pkg::OP_HALT, $urandom_range(0, MEM_WORDS - 1)));
      end else begin
         divisor_addr = (sb.pc + 50) % MEM_WORDS;
         write_word(AW'(divisor_addr), '0);
         write_word(sb.pc, encode(amex_pkg::OP_DIV, divisor_addr));
      end
      execute(random_data());
      execute(random_data());
      write_word(rand_addr(0, MEM_WORDS - 1), random_data());
      write_word(rand_addr(MEM_WORDS, 127), random_data());
      execute(random_data());
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
